[sv/dollar_hash_frame_receiver_macros.svh]
// assertion macros shared by the frame receiver modules
// expects clk and rst to be in scope where a macro is used
`ifndef DOLLAR_HASH_FRAME_RECEIVER_MACROS_SVH
`define DOLLAR_HASH_FRAME_RECEIVER_MACROS_SVH

// consequent checked in the same cycle
`define DHFR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define DHFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dhfr_pkg.sv]
// shared types and constants of the dollar-hash frame receiver
// no dependencies
package dhfr_pkg;

  localparam int FRAME_BYTES = 256;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 8;
  // two banks of two-byte rows
  localparam int ROW_W       = POS_W;
  localparam int ROWS        = 2 ** ROW_W;
  // entry held in each lane ram: byte valid flag over the byte
  localparam int ENTRY_W     = BYTE_W + 1;
  localparam int ERR_W       = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [POS_W:0]    FRAME_LIM = (POS_W + 1)'(FRAME_BYTES);
  localparam logic [POS_W-1:0]  LIMIT_CAP = POS_W'(FRAME_BYTES - 3);
  localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd200;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h52;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h54;
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;

  localparam logic [1:0] MODE_RX     = 2'd0;
  localparam logic [1:0] MODE_STATUS = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [1:0] ST_NONE     = 2'd0;
  localparam logic [1:0] ST_NEW      = 2'd1;
  localparam logic [1:0] ST_TRANSFER = 2'd2;
  localparam logic [1:0] ST_UNAUTH   = 2'd3;

  localparam logic [1:0] HP_HUNT    = 2'd0;
  localparam logic [1:0] HP_WAIT_R  = 2'd1;
  localparam logic [1:0] HP_PAYLOAD = 2'd2;

  localparam int PADDR_W = 3;
  localparam logic [0:0] REG_MAX_PAYLOAD = 1'b0;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_STATUS = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ROW_W-1:0] row;
    logic             lane;
    logic [BYTE_W-1:0] data;
    logic             done;
    logic             err;
    logic [ERR_W-1:0] etotal;
    logic [1:0]       phase;
  } cmd_t;

endpackage

[sv/dollar_hash_frame_receiver.sv]
// dollar-hash frame receiver: byte channel in, one result word per input word out
// each input word carries mode, rx_byte and read_index; mode 0 feeds a received
// byte, mode 1 reads the status of the read bank and clears both banks, mode 2
// reads one stored byte of the read bank, mode 3 only reports counters
// frames open with '$R' and close on '#', which swaps the two frame banks
// max_payload_bytes sits at apb addresses 0 to 3, written in the access cycle, pready high
// a result passes through the command queue, the s1 stage and the output register
// throughput: one word per cycle while out_ready is high, set by the single store
// access per word in the back end; the header hunt updates in the accept cycle
// a two-entry command queue and two back end stages decouple the sides; when
// out_ready stays low the back end holds its words, the queue fills and in_ready
// drops after at most four words in flight
// reset (rst, synchronous): hunt for '$', both banks read as zero, error count
// zero, limit 200; valid flags live in one flip-flop per two-byte row, so no
// clearing pass is needed and words are taken right after reset
// depends on dhfr_pkg, dhfr_front, dhfr_queue, dhfr_back
module dollar_hash_frame_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [7:0]                    rx_byte,
  input  logic [7:0]                    read_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status_code,
  output logic [7:0]                    read_data,
  output logic                          frame_done,
  output logic                          frame_error,
  output logic [dhfr_pkg::ERR_W-1:0]    error_total,
  output logic [1:0]                    hunt_phase,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dhfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [7:0]     max_payload_bytes;
  logic           reg_hit;
  logic           push, queue_full, q_valid, pop;
  dhfr_pkg::cmd_t push_cmd, q_cmd;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[dhfr_pkg::PADDR_W-1:2] == dhfr_pkg::REG_MAX_PAYLOAD);
  assign prdata  = reg_hit ? {24'h0, max_payload_bytes} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_bytes <= dhfr_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      max_payload_bytes <= pwdata[7:0];
    end
  end

  dhfr_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .mode              (mode),
    .rx_byte           (rx_byte),
    .read_index        (read_index),
    .max_payload_bytes (max_payload_bytes),
    .queue_full        (queue_full),
    .push              (push),
    .cmd               (push_cmd)
  );

  dhfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  dhfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status_code (status_code),
    .read_data   (read_data),
    .frame_done  (frame_done),
    .frame_error (frame_error),
    .error_total (error_total),
    .hunt_phase  (hunt_phase)
  );

endmodule

[sv/dhfr_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module dhfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/dhfr_front.sv]
// front end: takes words, runs the header hunt and frame tracking
// depends on dhfr_pkg; emits one command per word to the queue
module dhfr_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                mode,
  input  logic [7:0]                rx_byte,
  input  logic [7:0]                read_index,
  input  logic [7:0]                max_payload_bytes,
  input  logic                      queue_full,
  output logic                      push,
  output dhfr_pkg::cmd_t            cmd
);

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_WAIT_R  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  phase_t                         phase, phase_next;
  logic [dhfr_pkg::POS_W-1:0]     write_pos, write_pos_next;
  logic [dhfr_pkg::POS_W-1:0]     payload_count, payload_count_next;
  logic                           write_bank, write_bank_next;
  logic [dhfr_pkg::ERR_W-1:0]     error_count, error_count_next;

  logic [dhfr_pkg::POS_W-1:0]     limit;
  logic [dhfr_pkg::POS_W-1:0]     count_inc;
  logic [dhfr_pkg::POS_W-1:0]     acc_pos;
  logic                           acc_bank;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // the limit never lets a frame outgrow one bank
  assign limit = (max_payload_bytes > dhfr_pkg::LIMIT_CAP) ? dhfr_pkg::LIMIT_CAP
                                                           : max_payload_bytes;
  assign count_inc = payload_count + 1'b1;

  always_comb begin
    phase_next         = phase;
    write_pos_next     = write_pos;
    payload_count_next = payload_count;
    write_bank_next    = write_bank;
    error_count_next   = error_count;
    acc_pos            = '0;
    acc_bank           = write_bank;
    cmd.op             = dhfr_pkg::OP_NONE;
    cmd.data           = rx_byte;
    cmd.done           = 1'b0;
    cmd.err            = 1'b0;
    unique case (mode)
      dhfr_pkg::MODE_RX: begin
        unique case (phase)
          PH_WAIT_R: begin
            if (rx_byte == dhfr_pkg::CH_R) begin
              cmd.op             = dhfr_pkg::OP_WRITE;
              acc_pos            = dhfr_pkg::POS_W'(1);
              write_pos_next     = dhfr_pkg::POS_W'(2);
              payload_count_next = '0;
              phase_next         = PH_PAYLOAD;
            end else if (rx_byte == dhfr_pkg::CH_DOLLAR) begin
              // a second dollar restarts the header here
              cmd.op         = dhfr_pkg::OP_WRITE;
              acc_pos        = '0;
              write_pos_next = dhfr_pkg::POS_W'(1);
            end else begin
              phase_next = PH_HUNT;
            end
          end
          PH_PAYLOAD: begin
            acc_pos = write_pos;
            if ({1'b0, write_pos} < dhfr_pkg::FRAME_LIM) begin
              cmd.op = dhfr_pkg::OP_WRITE;
            end
            write_pos_next = write_pos + 1'b1;
            if (rx_byte == dhfr_pkg::CH_HASH) begin
              write_bank_next    = !write_bank;
              cmd.done           = 1'b1;
              phase_next         = PH_HUNT;
              write_pos_next     = '0;
              payload_count_next = '0;
            end else begin
              payload_count_next = count_inc;
              if (count_inc > limit) begin
                error_count_next   = error_count + 1'b1;
                cmd.err            = 1'b1;
                phase_next         = PH_HUNT;
                write_pos_next     = '0;
                payload_count_next = '0;
              end
            end
          end
          default: begin
            phase_next = PH_HUNT;
            if (rx_byte == dhfr_pkg::CH_DOLLAR) begin
              cmd.op         = dhfr_pkg::OP_WRITE;
              acc_pos        = '0;
              write_pos_next = dhfr_pkg::POS_W'(1);
              phase_next     = PH_WAIT_R;
            end
          end
        endcase
      end
      dhfr_pkg::MODE_STATUS: begin
        cmd.op   = dhfr_pkg::OP_STATUS;
        acc_bank = !write_bank;
        acc_pos  = '0;
      end
      dhfr_pkg::MODE_READ: begin
        acc_bank = !write_bank;
        acc_pos  = read_index;
        // past the bank reads as zero, nothing to fetch
        if ({1'b0, read_index} < dhfr_pkg::FRAME_LIM) begin
          cmd.op = dhfr_pkg::OP_READ;
        end
      end
      default: begin
        cmd.op = dhfr_pkg::OP_NONE;
      end
    endcase
    cmd.row    = {acc_bank, acc_pos[dhfr_pkg::POS_W-1:1]};
    cmd.lane   = acc_pos[0];
    cmd.etotal = error_count_next;
    unique case (phase_next)
      PH_WAIT_R:  cmd.phase = dhfr_pkg::HP_WAIT_R;
      PH_PAYLOAD: cmd.phase = dhfr_pkg::HP_PAYLOAD;
      default:    cmd.phase = dhfr_pkg::HP_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      write_pos     <= '0;
      payload_count <= '0;
      write_bank    <= 1'b0;
      error_count   <= '0;
    end else if (push) begin
      phase         <= phase_next;
      write_pos     <= write_pos_next;
      payload_count <= payload_count_next;
      write_bank    <= write_bank_next;
      error_count   <= error_count_next;
    end
  end

endmodule

[sv/dhfr_queue.sv]
// short command queue between the front end and the store back end
// depends on dhfr_pkg and the assertion macro header
`include "dollar_hash_frame_receiver_macros.svh"

module dhfr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dhfr_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           q_valid,
  output dhfr_pkg::cmd_t q_cmd,
  input  logic           pop
);

  localparam int PTR_W = (dhfr_pkg::QUEUE_DEPTH > 1) ? $clog2(dhfr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(dhfr_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(dhfr_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(dhfr_pkg::QUEUE_DEPTH);

  dhfr_pkg::cmd_t   slots [dhfr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_FULL);
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `DHFR_ASSERT_SAME(a_no_push_full, push, !full, "queue written while full")
  `DHFR_ASSERT_SAME(a_no_pop_empty, pop, q_valid, "queue read while empty")
  `DHFR_ASSERT_NEXT(a_fill_count, push && !pop, count == $past(count) + 1'b1, "queue fill count slipped")

endmodule

[sv/dhfr_back.sv]
// back end: executes queued commands against the frame store, builds results
// depends on dhfr_pkg, dhfr_ram and the assertion macro header
`include "dollar_hash_frame_receiver_macros.svh"

module dhfr_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  dhfr_pkg::cmd_t               q_cmd,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status_code,
  output logic [7:0]                   read_data,
  output logic                         frame_done,
  output logic                         frame_error,
  output logic [dhfr_pkg::ERR_W-1:0]   error_total,
  output logic [1:0]                   hunt_phase
);

  logic                           issue, out_load;
  logic [dhfr_pkg::ROWS-1:0]      rowvalid;
  logic                           is_write, rd_en;
  logic                           ev_we, od_we;
  logic [dhfr_pkg::ENTRY_W-1:0]   ev_wdata, od_wdata, ev_q, od_q;

  logic                           s1_valid;
  dhfr_pkg::op_t                  s1_op;
  logic                           s1_lane, s1_rv, s1_done, s1_err;
  logic [dhfr_pkg::ERR_W-1:0]     s1_etotal;
  logic [1:0]                     s1_phase;

  logic [7:0]                     even_byte, odd_byte;
  logic [1:0]                     status_next;
  logic [7:0]                     rdata_next;

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign issue    = q_valid && (!s1_valid || out_load);
  assign pop      = issue;

  assign is_write = issue && (q_cmd.op == dhfr_pkg::OP_WRITE);
  assign rd_en    = issue && ((q_cmd.op == dhfr_pkg::OP_STATUS) ||
                              (q_cmd.op == dhfr_pkg::OP_READ));

  // first write into a cleared row also drops the partner byte's flag
  assign ev_we    = is_write && (!q_cmd.lane || !rowvalid[q_cmd.row]);
  assign od_we    = is_write && (q_cmd.lane || !rowvalid[q_cmd.row]);
  assign ev_wdata = q_cmd.lane ? '0 : {1'b1, q_cmd.data};
  assign od_wdata = q_cmd.lane ? {1'b1, q_cmd.data} : '0;

  dhfr_ram #(
    .WIDTH (dhfr_pkg::ENTRY_W),
    .DEPTH (dhfr_pkg::ROWS)
  ) u_even_ram (
    .clk   (clk),
    .we    (ev_we),
    .waddr (q_cmd.row),
    .wdata (ev_wdata),
    .re    (rd_en),
    .raddr (q_cmd.row),
    .rdata (ev_q)
  );

  dhfr_ram #(
    .WIDTH (dhfr_pkg::ENTRY_W),
    .DEPTH (dhfr_pkg::ROWS)
  ) u_odd_ram (
    .clk   (clk),
    .we    (od_we),
    .waddr (q_cmd.row),
    .wdata (od_wdata),
    .re    (rd_en),
    .raddr (q_cmd.row),
    .rdata (od_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rowvalid <= '0;
    end else if (issue && (q_cmd.op == dhfr_pkg::OP_STATUS)) begin
      rowvalid <= '0;
    end else if (is_write) begin
      rowvalid[q_cmd.row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_op     <= q_cmd.op;
      s1_lane   <= q_cmd.lane;
      s1_rv     <= rowvalid[q_cmd.row];
      s1_done   <= q_cmd.done;
      s1_err    <= q_cmd.err;
      s1_etotal <= q_cmd.etotal;
      s1_phase  <= q_cmd.phase;
    end
  end

  assign even_byte = (s1_rv && ev_q[dhfr_pkg::BYTE_W]) ? ev_q[dhfr_pkg::BYTE_W-1:0] : '0;
  assign odd_byte  = (s1_rv && od_q[dhfr_pkg::BYTE_W]) ? od_q[dhfr_pkg::BYTE_W-1:0] : '0;

  always_comb begin
    status_next = dhfr_pkg::ST_NONE;
    rdata_next  = '0;
    unique case (s1_op)
      dhfr_pkg::OP_STATUS: begin
        if (even_byte == dhfr_pkg::CH_DOLLAR) begin
          if (odd_byte == dhfr_pkg::CH_R) begin
            status_next = dhfr_pkg::ST_NEW;
          end else if (odd_byte == dhfr_pkg::CH_T) begin
            status_next = dhfr_pkg::ST_TRANSFER;
          end else begin
            status_next = dhfr_pkg::ST_UNAUTH;
          end
        end
      end
      dhfr_pkg::OP_READ: begin
        rdata_next = s1_lane ? odd_byte : even_byte;
      end
      default: begin
        rdata_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_code <= status_next;
      read_data   <= rdata_next;
      frame_done  <= s1_done;
      frame_error <= s1_err;
      error_total <= s1_etotal;
      hunt_phase  <= s1_phase;
    end
  end

  `DHFR_ASSERT_NEXT(a_status_clears, issue && (q_cmd.op == dhfr_pkg::OP_STATUS), rowvalid == '0, "status read left rows valid")
  `DHFR_ASSERT_NEXT(a_write_marks, is_write, rowvalid[$past(q_cmd.row)], "written row not marked valid")
  `DHFR_ASSERT_NEXT(a_stage_holds, s1_valid && !out_load, s1_valid && $stable(s1_op), "stalled stage lost its word")

endmodule

[dv/tb_top.sv]
// tb_top: directed then random words into the dollar-hash frame receiver, with
// an in-bench frame tracker predicting each result word and checking it per field
// depends on dhfr_pkg and dollar_hash_frame_receiver
module tb_top;

  localparam logic [1:0] MODE_IDLE = 2'd3;
  localparam logic [dhfr_pkg::PADDR_W-1:0] LIMIT_ADDR =
    dhfr_pkg::PADDR_W'(4 * dhfr_pkg::REG_MAX_PAYLOAD);

  typedef struct packed {
    logic [1:0]                 status;
    logic [7:0]                 data;
    logic                       done;
    logic                       err;
    logic [dhfr_pkg::ERR_W-1:0] errs;
    logic [1:0]                 phase;
  } rx_result_t;

  class frame_rx_tracker;
    logic [7:0]                 limit;
    logic [1:0]                 phase;
    logic [7:0]                 wpos;
    logic [7:0]                 pcount;
    logic                       wbank;
    logic [dhfr_pkg::ERR_W-1:0] errs;
    logic [7:0]                 store [2*dhfr_pkg::FRAME_BYTES];
    bit                         valid [2*dhfr_pkg::FRAME_BYTES];
    rx_result_t                 awaited [$];
    int                         failures, checked, closed, errored, statuses, reads;

    function new();
      limit = dhfr_pkg::LIMIT_RESET;
      wbank = 1'b0;
      errs = '0;
      resync();
      foreach (valid[i]) begin
        valid[i] = 1'b0;
        store[i] = 8'h00;
      end
    endfunction

    function int eff_limit();
      return (limit > dhfr_pkg::LIMIT_CAP) ? int'(dhfr_pkg::LIMIT_CAP) : int'(limit);
    endfunction

    function void resync();
      phase = dhfr_pkg::HP_HUNT;
      wpos = 8'd0;
      pcount = 8'd0;
    endfunction

    function void put(logic [7:0] pos, logic [7:0] v);
      int a;
      a = {wbank, pos};
      store[a] = v;
      valid[a] = 1'b1;
    endfunction

    function logic [7:0] fetch(logic [7:0] pos);
      int a;
      a = {~wbank, pos};
      return valid[a] ? store[a] : 8'h00;
    endfunction

    // mostly low positions, now and then anywhere in the bank
    function int pick_index();
      if ($urandom_range(3) == 0) return int'($urandom_range(255));
      return int'($urandom_range(15));
    endfunction

    function void take_word(logic [1:0] m, logic [7:0] b, logic [7:0] idx);
      rx_result_t r;
      logic [7:0] c;
      r = '0;
      case (m)
        dhfr_pkg::MODE_RX: begin
          case (phase)
            dhfr_pkg::HP_WAIT_R: begin
              if (b == dhfr_pkg::CH_R) begin
                put(8'd1, b);
                wpos = 8'd2;
                pcount = 8'd0;
                phase = dhfr_pkg::HP_PAYLOAD;
              end else if (b == dhfr_pkg::CH_DOLLAR) begin
                put(8'd0, b);
                wpos = 8'd1;
              end else begin
                phase = dhfr_pkg::HP_HUNT;
              end
            end
            dhfr_pkg::HP_PAYLOAD: begin
              put(wpos, b);
              wpos = wpos + 8'd1;
              if (b == dhfr_pkg::CH_HASH) begin
                wbank = ~wbank;
                r.done = 1'b1;
                closed++;
                resync();
              end else begin
                pcount = pcount + 8'd1;
                if (int'(pcount) > eff_limit()) begin
                  errs = errs + 1'b1;
                  r.err = 1'b1;
                  errored++;
                  resync();
                end
              end
            end
            default: begin
              phase = dhfr_pkg::HP_HUNT;
              if (b == dhfr_pkg::CH_DOLLAR) begin
                put(8'd0, b);
                wpos = 8'd1;
                phase = dhfr_pkg::HP_WAIT_R;
              end
            end
          endcase
        end
        dhfr_pkg::MODE_STATUS: begin
          statuses++;
          if (fetch(8'd0) == dhfr_pkg::CH_DOLLAR) begin
            c = fetch(8'd1);
            if (c == dhfr_pkg::CH_R) r.status = dhfr_pkg::ST_NEW;
            else if (c == dhfr_pkg::CH_T) r.status = dhfr_pkg::ST_TRANSFER;
            else r.status = dhfr_pkg::ST_UNAUTH;
          end
          // flash clear of both banks, receiver state untouched
          foreach (valid[i]) valid[i] = 1'b0;
        end
        dhfr_pkg::MODE_READ: begin
          reads++;
          r.data = fetch(idx);
        end
        default: ;
      endcase
      r.errs = errs;
      r.phase = phase;
      awaited.push_back(r);
    endfunction

    task report(string msg);
      failures++;
      $display("mismatch: %s", msg);
    endtask

    task compare(string what, int unsigned got, int unsigned want);
      if (got != want)
        report($sformatf("word %0d %s got %0h want %0h", checked, what, got, want));
    endtask

    task check_result(rx_result_t got);
      rx_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        report($sformatf("word %0d arrived with nothing awaited", checked));
        return;
      end
      want = awaited.pop_front();
      compare("status_code", got.status, want.status);
      compare("read_data", got.data, want.data);
      compare("frame_done", got.done, want.done);
      compare("frame_error", got.err, want.err);
      compare("error_total", got.errs, want.errs);
      compare("hunt_phase", got.phase, want.phase);
    endtask
  endclass

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [1:0]                   mode;
  logic [7:0]                   rx_byte;
  logic [7:0]                   read_index;
  logic                         out_valid;
  logic                         out_ready;
  logic [1:0]                   status_code;
  logic [7:0]                   read_data;
  logic                         frame_done;
  logic                         frame_error;
  logic [dhfr_pkg::ERR_W-1:0]   error_total;
  logic [1:0]                   hunt_phase;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [dhfr_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  int tx_gap_pct;
  int rx_gap_pct;
  int words;
  frame_rx_tracker rx;

  dollar_hash_frame_receiver uut (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_gap_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      rx.check_result(rx_result_t'{status_code, read_data, frame_done, frame_error,
                                   error_total, hunt_phase});
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(255));
  endfunction

  // any byte but the closing hash
  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    b = rnd_byte();
    return (b == dhfr_pkg::CH_HASH) ? ~b : b;
  endfunction

  function automatic logic [7:0] not_header();
    logic [7:0] b;
    b = rnd_byte();
    return (b == dhfr_pkg::CH_R || b == dhfr_pkg::CH_DOLLAR) ? ~b : b;
  endfunction

  task automatic send_word(input logic [1:0] m, input logic [7:0] b, input logic [7:0] idx);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    rx_byte <= b;
    read_index <= idx;
    do @(posedge clk); while (!in_ready);
    rx.take_word(m, b, idx);
    if (m != MODE_IDLE) words++;
  endtask

  task automatic side_word();
    int k;
    int i;
    k = $urandom_range(9);
    i = rx.pick_index();
    if (k < 4) send_word(dhfr_pkg::MODE_STATUS, rnd_byte(), rnd_byte());
    else if (k < 8) send_word(dhfr_pkg::MODE_READ, rnd_byte(), 8'(i));
    else send_word(MODE_IDLE, rnd_byte(), rnd_byte());
  endtask

  task automatic send_frame(input int len, input bit close);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_DOLLAR, rnd_byte());
    if ($urandom_range(4) == 0) send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_DOLLAR, rnd_byte());
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_R, rnd_byte());
    for (int n = 0; n < len; n++) begin
      if ($urandom_range(15) == 0) side_word();
      send_word(dhfr_pkg::MODE_RX, payload_byte(), rnd_byte());
    end
    if (close) send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_HASH, rnd_byte());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rx.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIMIT_ADDR;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    rx.limit = v;
  endtask

  task automatic run_phase(input int n, input logic [7:0] lim, input int tx_pct,
                           input int rx_pct);
    int target;
    int k;
    bit big;
    drain();
    tx_gap_pct = tx_pct;
    rx_gap_pct = rx_pct;
    write_limit(lim);
    target = words + n;
    // open each setting with a frame of exactly the limit
    send_frame(rx.eff_limit(), 1'b1);
    while (words < target) begin
      k = $urandom_range(99);
      big = (rx.eff_limit() < 16) || ($urandom_range(19) == 0);
      if (k < 8) begin
        send_word(dhfr_pkg::MODE_RX, rnd_byte(), rnd_byte());
      end else if (k < 14) begin
        send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_DOLLAR, rnd_byte());
        send_word(dhfr_pkg::MODE_RX, not_header(), rnd_byte());
      end else if (k < 22) begin
        side_word();
      end else if (k < 30 && big) begin
        send_frame(rx.eff_limit() + 1, 1'b0);
      end else if (k < 38 && big) begin
        send_frame(rx.eff_limit(), 1'b1);
      end else begin
        send_frame($urandom_range(rx.eff_limit() < 8 ? rx.eff_limit() : 8), 1'b1);
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("dollar_hash_frame_receiver verification failed");
    $finish;
  end

  initial begin
    rx = new();
    rst = 1'b1;
    in_valid = 1'b0;
    mode = dhfr_pkg::MODE_RX;
    rx_byte = 8'h00;
    read_index = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = 32'h0;
    tx_gap_pct = 17;
    rx_gap_pct = 55;
    words = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset limit, broken and restarted headers, swap, status, reads
    send_word(MODE_IDLE, 8'hFF, 8'hFF);
    send_word(dhfr_pkg::MODE_READ, 8'h00, 8'd0);
    send_word(dhfr_pkg::MODE_STATUS, 8'h00, 8'h00);
    send_word(dhfr_pkg::MODE_RX, 8'h00, 8'hFF);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_DOLLAR, 8'h00);
    send_word(dhfr_pkg::MODE_RX, 8'h41, 8'h00);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_DOLLAR, 8'h00);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_DOLLAR, 8'h00);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_R, 8'h00);
    send_word(dhfr_pkg::MODE_RX, 8'hFF, 8'h00);
    send_word(dhfr_pkg::MODE_RX, 8'h00, 8'h00);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_DOLLAR, 8'h00);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_HASH, 8'h00);
    send_word(dhfr_pkg::MODE_STATUS, 8'h00, 8'h00);
    send_word(dhfr_pkg::MODE_STATUS, 8'hFF, 8'hFF);
    send_word(dhfr_pkg::MODE_READ, 8'h00, 8'd5);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_DOLLAR, 8'h00);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_R, 8'h00);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_HASH, 8'h00);
    send_word(dhfr_pkg::MODE_READ, 8'h00, 8'd2);
    send_word(dhfr_pkg::MODE_READ, 8'h00, 8'd0);
    send_word(dhfr_pkg::MODE_READ, 8'h00, 8'd200);
    drain();
    // zero limit: first payload byte is already a frame error
    write_limit(8'd0);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_DOLLAR, 8'h00);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_R, 8'h00);
    send_word(dhfr_pkg::MODE_RX, 8'h41, 8'h00);
    send_word(dhfr_pkg::MODE_RX, dhfr_pkg::CH_HASH, 8'h00);
    send_word(dhfr_pkg::MODE_STATUS, 8'h00, 8'h00);

    run_phase(292, 8'd255, 17, 55);
    run_phase(292, 8'd3, 17, 55);
    run_phase(292, 8'd0, 55, 17);
    run_phase(292, 8'd12, 55, 17);
    run_phase(292, 8'd253, 0, 0);
    run_phase(290, 8'd1, 0, 0);
    drain();

    $display("%0d words sent: %0d frames closed, %0d overlong, %0d status, %0d byte reads",
             words, rx.closed, rx.errored, rx.statuses, rx.reads);
    $display("limits from zero to past the cap, with slow, busy and idle-free traffic");
    if (rx.failures == 0) begin
      $display("dollar_hash_frame_receiver verification clean");
    end else begin
      $display("dollar_hash_frame_receiver verification failed");
    end
    $finish;
  end
endmodule
